>>> design/mrrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_pkg
// Shared constants, types and helpers for the multi-reader ring buffer.
// ----------------------------------------------------------------------------
package mrrb_pkg;

  localparam int CHANNELS   = 4;
  localparam int SLOTS      = 16;
  localparam int READERS    = 8;
  localparam int WORD_WIDTH = 32;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD_W    = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int PTR_W   = $clog2(SLOTS);
  localparam int SLOT_AW = $clog2(CHANNELS * SLOTS);

  // Depth of the queue between the front and the back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_ATTACH = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_LOST    = 3'd2,
    ST_INVALID = 3'd3,
    ST_WRITTEN = 3'd4
  } status_t;

  // Classification made by the front
  typedef enum logic [2:0] {
    CLS_WRITE,
    CLS_READ,
    CLS_ATTACH,
    CLS_DETACH,
    CLS_INVALID
  } cls_t;

  typedef struct packed {
    cls_t                  cls;
    logic [CH_W-1:0]       chan;
    logic [RD_W-1:0]       rdr;
    logic [WORD_WIDTH-1:0] data;
  } q_item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_RESP
  } back_state_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    ptr_adv = (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

>>> design/mrrb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_front
// Accepts input transfers, range-checks them and pushes a classified item.
// ----------------------------------------------------------------------------
module mrrb_front import mrrb_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_reader,
  input  logic [31:0] in_data_word,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output q_item_t     q_wdata
);

  logic ch_ok;
  logic rd_ok;
  cls_t cls;

  assign ch_ok = 32'(in_channel) < CHANNELS;
  assign rd_ok = 32'(in_reader) < READERS;

  always_comb begin
    case (in_operation)
      OP_WRITE:  cls = ch_ok ? CLS_WRITE : CLS_INVALID;
      OP_READ:   cls = rd_ok ? CLS_READ : CLS_INVALID;
      OP_ATTACH: cls = !rd_ok ? CLS_INVALID : (ch_ok ? CLS_ATTACH : CLS_DETACH);
      default:   cls = CLS_INVALID;
    endcase
  end

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  assign q_wdata.cls  = cls;
  assign q_wdata.chan = CH_W'(in_channel);
  assign q_wdata.rdr  = RD_W'(in_reader);
  assign q_wdata.data = WORD_WIDTH'(in_data_word);

endmodule

>>> design/mrrb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_queue
// Short FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module mrrb_queue import mrrb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  input  logic    pop,
  output q_item_t rdata,
  output q_stat_t stat
);

  q_item_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] qadv(input logic [QPTR_W-1:0] p);
    qadv = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? qadv(wptr_r) : wptr_r;
    rptr_nxt = pop ? qadv(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");

endmodule

>>> design/mrrb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrb_back
// Executes queued items against pointer state and the slot memory.
// ----------------------------------------------------------------------------
module mrrb_back import mrrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  q_item_t     q_rdata,
  output logic        q_pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_word,
  output logic [7:0]  out_read_type
);

  back_state_t state_r, state_nxt;

  q_item_t item_r;

  logic [PTR_W-1:0] wp_r    [CHANNELS];
  logic [PTR_W-1:0] wp_nxt  [CHANNELS];
  logic [PTR_W-1:0] beg_r   [READERS];
  logic [PTR_W-1:0] beg_nxt [READERS];
  logic [PTR_W-1:0] end_r   [READERS];
  logic [PTR_W-1:0] end_nxt [READERS];
  logic [CH_W-1:0]  chn_r   [READERS];
  logic [CH_W-1:0]  chn_nxt [READERS];
  logic [READERS-1:0] att_r, att_nxt;

  logic [WORD_WIDTH-1:0] slot_mem [CHANNELS * SLOTS];
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic [SLOT_AW-1:0]    mem_addr;
  logic                  mem_we;
  logic                  mem_re;

  status_t res_r, res_nxt;
  logic [7:0] data_type_r;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [WORD_WIDTH-1:0] out_word_r;
  logic [7:0]            out_type_r;

  logic            can_load;
  logic            load;
  logic [CH_W-1:0] c;
  logic [PTR_W-1:0] b, e, w;
  logic            in_order;

  assign can_load = !out_valid_r || !out_stall;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_EXEC;
      BK_EXEC: state_nxt = BK_RESP;
      BK_RESP: if (can_load) state_nxt = q_stat.empty ? BK_IDLE : BK_EXEC;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // ---- state outputs ----
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = !q_stat.empty;
      BK_EXEC: ;
      BK_RESP: begin
        load  = can_load;
        q_pop = can_load && !q_stat.empty;
      end
      default: ;
    endcase
  end

  // ---- pointer work in EXEC ----
  assign c = (item_r.cls == CLS_READ) ? chn_r[item_r.rdr] : item_r.chan;
  assign b = beg_r[item_r.rdr];
  assign e = end_r[item_r.rdr];
  assign w = wp_r[c];
  assign in_order = (b <= e && e <= w) || (e <= w && w <= b) || (w <= b && b <= e);

  always_comb begin
    wp_nxt  = wp_r;
    beg_nxt = beg_r;
    end_nxt = end_r;
    chn_nxt = chn_r;
    att_nxt = att_r;
    res_nxt = res_r;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_addr = SLOT_AW'(SLOT_AW'(c) * SLOT_AW'(SLOTS) + SLOT_AW'(w));
    if (state_r == BK_EXEC) begin
      case (item_r.cls)
        CLS_WRITE: begin
          mem_we    = 1'b1;
          wp_nxt[c] = ptr_adv(w);
          res_nxt   = ST_WRITTEN;
        end
        CLS_ATTACH: begin
          chn_nxt[item_r.rdr] = c;
          beg_nxt[item_r.rdr] = w;
          end_nxt[item_r.rdr] = w;
          att_nxt[item_r.rdr] = 1'b1;
          res_nxt = ST_EMPTY;
        end
        CLS_DETACH: begin
          att_nxt[item_r.rdr] = 1'b0;
          res_nxt = ST_INVALID;
        end
        CLS_READ: begin
          if (!att_r[item_r.rdr]) begin
            res_nxt = ST_INVALID;
          end else if (b == e && e == w) begin
            res_nxt = ST_EMPTY;
          end else if (in_order) begin
            mem_re   = 1'b1;
            mem_addr = SLOT_AW'(SLOT_AW'(c) * SLOT_AW'(SLOTS) + SLOT_AW'(b));
            end_nxt[item_r.rdr] = w;
            beg_nxt[item_r.rdr] = ptr_adv(b);
            res_nxt = ST_DATA;
          end else begin
            end_nxt[item_r.rdr] = w;
            beg_nxt[item_r.rdr] = w;
            res_nxt = ST_LOST;
          end
        end
        default: res_nxt = ST_INVALID;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      data_type_r <= '0;
      att_r       <= '0;
      for (int i = 0; i < CHANNELS; i++) wp_r[i] <= '0;
      for (int i = 0; i < READERS; i++) begin
        beg_r[i] <= '0;
        end_r[i] <= '0;
        chn_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      att_r       <= att_nxt;
      wp_r        <= wp_nxt;
      beg_r       <= beg_nxt;
      end_r       <= end_nxt;
      chn_r       <= chn_nxt;
      if (cfg_valid && cfg_ready) data_type_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_rdata;
    res_r <= res_nxt;
    if (load) begin
      out_status_r <= res_r;
      out_word_r   <= (res_r == ST_DATA) ? rd_data_r : '0;
      out_type_r   <= (res_r == ST_DATA) ? data_type_r : '0;
    end
  end

  // Slot memory, at most one access per cycle, only in the execute state
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_addr] <= item_r.data;
    if (mem_re) rd_data_r <= slot_mem[mem_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_word = 32'(out_word_r);
  assign out_read_type = out_type_r;

  a_pop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE || state_r == BK_RESP))
    else $error("pop outside idle or response phase");
  a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> state_r == BK_RESP)
    else $error("execute not followed by response");
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we || mem_re) |-> (state_r == BK_EXEC && !(mem_we && mem_re)))
    else $error("slot memory access outside execute");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("output overwritten while held");

endmodule

>>> design/multi_reader_ring_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer_core
// Per-channel overwriting slot rings with one writer and several readers.
// ----------------------------------------------------------------------------
// Idle core: a transfer passes the queue entry and the item, result and output
// registers before out_valid rises. Each item gets an execute and a response
// pass of the back end, held by out_stall; slot memory is used once, in execute.
// Reset (rst_n, synchronous): clears queue, FSM, write positions, reader marks,
//   attach bits and the type tag. Slot memory is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer_core import mrrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_reader,
  input  logic [31:0] in_data_word,
  // configuration: data type tag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_word,
  output logic [7:0]  out_read_type
);

  // front -> queue -> back
  q_stat_t q_stat;
  q_item_t q_wdata;
  q_item_t q_rdata;
  logic    q_push;
  logic    q_pop;

  // Front: range checks and classification; stalls only when the queue is full,
  // so a transfer can be taken while a finished result waits at the output.
  mrrb_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_channel   (in_channel),
    .in_reader    (in_reader),
    .in_data_word (in_data_word),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Two-entry decoupling queue
  mrrb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: pointer read-modify-write, slot memory access, output register
  mrrb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_word (out_read_word),
    .out_read_type (out_read_type)
  );

endmodule

>>> test/multi_reader_ring_buffer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer_core_tb
// Self-checking bench for the multi-reader ring buffer core. A behavioural
// copy of the rings, write positions and reader marks predicts one result per
// accepted transfer. Results are checked in order, field by field, under
// several idling and stalling mixes and several type tag settings.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer_core_tb;
  import mrrb_pkg::*;

  // No enum member for the spare opcode; the block must reject it
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  // Cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // Cycles from an input transfer to its result when the core is idle, plus margin
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [1:0]            op;
    logic [CH_W-1:0]       chan;
    logic [RD_W-1:0]       rdr;
    logic [WORD_WIDTH-1:0] word;
  } ring_op_t;

  typedef struct {
    status_t               status;
    logic [WORD_WIDTH-1:0] word;
    logic [7:0]            tag;
  } ring_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [1:0]  in_channel;
  logic [2:0]  in_reader;
  logic [31:0] in_data_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_read_word;
  logic [7:0]  out_read_type;

  multi_reader_ring_buffer_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_channel   (in_channel),
    .in_reader    (in_reader),
    .in_data_word (in_data_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_read_word(out_read_word),
    .out_read_type(out_read_type)
  );

  // --------------------------------------------------------------------------
  // Ring state as the bench believes it to be
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0]      wr_pos       [CHANNELS];
  logic [WORD_WIDTH-1:0] slot_mem     [CHANNELS][SLOTS];
  bit                    slot_written [CHANNELS][SLOTS];
  logic [PTR_W-1:0]      mark_begin   [READERS];
  logic [PTR_W-1:0]      mark_end     [READERS];
  logic [CH_W-1:0]       rdr_chan     [READERS];
  bit                    rdr_bound    [READERS];
  logic [7:0]            type_tag;

  ring_result_t expected_results[$];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct;
  int           stall_pct;

  always #1 clk = ~clk;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = PTR_W'((p + 1) % SLOTS);
  endfunction

  // One step of the ring. With apply clear it only predicts, so the sender
  // can spot a read that would land on a slot never written. blank flags that.
  function automatic void ring_step(input ring_op_t it, input bit apply,
                                    output ring_result_t res, output bit blank);
    logic [PTR_W-1:0] b;
    logic [PTR_W-1:0] e;
    logic [PTR_W-1:0] w;
    logic [CH_W-1:0]  c;
    blank      = 1'b0;
    res.status = ST_INVALID;
    res.word   = '0;
    res.tag    = '0;
    case (it.op)
      OP_WRITE: begin
        res.status = ST_WRITTEN;
        if (apply) begin
          slot_mem[it.chan][wr_pos[it.chan]]     = it.word;
          slot_written[it.chan][wr_pos[it.chan]] = 1'b1;
          wr_pos[it.chan] = next_slot(wr_pos[it.chan]);
        end
      end
      OP_ATTACH: begin
        // every channel and reader index the fields can carry is in range
        res.status = ST_EMPTY;
        if (apply) begin
          rdr_chan[it.rdr]   = it.chan;
          mark_begin[it.rdr] = wr_pos[it.chan];
          mark_end[it.rdr]   = wr_pos[it.chan];
          rdr_bound[it.rdr]  = 1'b1;
        end
      end
      OP_READ: begin
        if (rdr_bound[it.rdr]) begin
          c = rdr_chan[it.rdr];
          b = mark_begin[it.rdr];
          e = mark_end[it.rdr];
          w = wr_pos[c];
          if (b == e && e == w) begin
            res.status = ST_EMPTY;
          end else if ((b <= e && e <= w) || (e <= w && w <= b) || (w <= b && b <= e)) begin
            res.status = ST_DATA;
            res.word   = slot_mem[c][b];
            res.tag    = type_tag;
            blank      = !slot_written[c][b];
            if (apply) begin
              mark_end[it.rdr]   = w;
              mark_begin[it.rdr] = next_slot(b);
            end
          end else begin
            // writer lapped the reader: resync both marks
            res.status = ST_LOST;
            if (apply) begin
              mark_end[it.rdr]   = w;
              mark_begin[it.rdr] = w;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic ring_op_t make_op(input logic [1:0] op, input logic [CH_W-1:0] chan,
                                       input logic [RD_W-1:0] rdr,
                                       input logic [WORD_WIDTH-1:0] word);
    make_op.op   = op;
    make_op.chan = chan;
    make_op.rdr  = rdr;
    make_op.word = word;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transfer per call, random gap in front of it
  // --------------------------------------------------------------------------
  task automatic send_op(input ring_op_t it);
    ring_result_t res;
    bit           blank;
    int           gap;
    ring_step(it, 1'b0, res, blank);
    if (blank) begin
      // a read of a never-written slot is out of contract; feed that ring instead
      it.op   = OP_WRITE;
      it.chan = rdr_chan[it.rdr];
    end
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= it.op;
    in_channel   <= it.chan;
    in_reader    <= it.rdr;
    in_data_word <= it.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    ring_step(it, 1'b1, res, blank);
    expected_results.push_back(res);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Type tag writes only happen with the core idle
  task automatic write_type_tag(input logic [7:0] tag);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tag;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    type_tag = tag;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, in-order compare
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d word %h type %h",
               out_status, out_read_word, out_read_type);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_read_word !== want.word) begin
          $error("read_word: expected %h, got %h", want.word, out_read_word);
          fail_count++;
        end
        if (out_read_type !== want.tag) begin
          $error("read_type: expected %h, got %h", want.tag, out_read_type);
          fail_count++;
        end
      end
    end
  end

  // Hang detector: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL multi_reader_ring_buffer_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Read by a reader never attached, and the spare opcode with all fields high
  task automatic test_unattached_and_unknown();
    send_op(make_op(OP_READ, 2'd0, 3'd0, 32'h0000_0000));
    send_op(make_op(OP_UNKNOWN, 2'd3, 3'd7, 32'hFFFF_FFFF));
  endtask

  // Attach, empty read, a data read of the all-zero word, then lap the reader
  // so the next read reports a lost frame, then empty again after resync
  task automatic test_attach_read_lost();
    int k;
    send_op(make_op(OP_ATTACH, 2'd3, 3'd7, 32'h0));
    send_op(make_op(OP_READ, 2'd0, 3'd7, 32'h0));
    send_op(make_op(OP_WRITE, 2'd3, 3'd0, 32'h0000_0000));
    send_op(make_op(OP_WRITE, 2'd3, 3'd0, 32'hFFFF_FFFF));
    send_op(make_op(OP_WRITE, 2'd3, 3'd0, 32'hA5A5_5A5A));
    // begin 0, end 0, write 3: returns slot 0, marks become 1 and 3
    send_op(make_op(OP_READ, 2'd0, 3'd7, 32'h0));
    // 15 more writes put the write position at 2, strictly inside 1..3
    for (k = 0; k < 15; k++) begin
      send_op(make_op(OP_WRITE, 2'd3, 3'd0, 32'h0000_0001 << k));
    end
    send_op(make_op(OP_READ, 2'd0, 3'd7, 32'h0));
    send_op(make_op(OP_READ, 2'd0, 3'd7, 32'h0));
  endtask

  // Random traffic built from write bursts, read bursts, attaches and noise
  task automatic test_random_traffic(input int n_ops, input int idle_pct, input int stl_pct,
                                     input bit pause_once);
    int       sent;
    int       kind;
    int       len;
    int       k;
    bit       paused;
    logic [CH_W-1:0] ch;
    logic [RD_W-1:0] rd;
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    sent          = 0;
    paused        = 1'b0;
    while (sent < n_ops) begin
      if (pause_once && !paused && sent >= n_ops / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      ch   = CH_W'($urandom_range(CHANNELS - 1));
      rd   = RD_W'($urandom_range(READERS - 1));
      if (kind < 40) begin
        // long bursts let the writer lap lagging readers
        len = $urandom_range(20, 1);
        for (k = 0; k < len && sent < n_ops; k++) begin
          send_op(make_op(OP_WRITE, ch, RD_W'($urandom), $urandom));
          sent++;
        end
      end else if (kind < 75) begin
        len = $urandom_range(6, 1);
        for (k = 0; k < len && sent < n_ops; k++) begin
          send_op(make_op(OP_READ, CH_W'($urandom), rd, $urandom));
          sent++;
        end
      end else if (kind < 88) begin
        send_op(make_op(OP_ATTACH, ch, rd, $urandom));
        sent++;
      end else begin
        send_op(make_op(2'($urandom_range(3)), ch, rd, $urandom));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = '0;
    in_channel    = '0;
    in_reader     = '0;
    in_data_word  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    type_tag      = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      wr_pos[c] = '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_mem[c][s]     = '0;
        slot_written[c][s] = 1'b0;
      end
    end
    for (int r = 0; r < READERS; r++) begin
      mark_begin[r] = '0;
      mark_end[r]   = '0;
      rdr_chan[r]   = '0;
      rdr_bound[r]  = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part runs with the reset type tag of zero
    test_unattached_and_unknown();
    test_attach_read_lost();

    write_type_tag(8'hFF);
    test_random_traffic(130, 0, 0, 1'b0);
    write_type_tag(8'h00);
    test_random_traffic(130, 72, 0, 1'b1);
    write_type_tag(8'($urandom_range(254, 1)));
    test_random_traffic(130, 0, 72, 1'b0);
    write_type_tag(8'($urandom_range(254, 1)));
    test_random_traffic(130, 15, 15, 1'b0);

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS multi_reader_ring_buffer_core");
    end else begin
      $display("FAIL multi_reader_ring_buffer_core");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mrrb_pkg.sv
design/mrrb_front.sv
design/mrrb_queue.sv
design/mrrb_back.sv
design/multi_reader_ring_buffer_core.sv
test/multi_reader_ring_buffer_core_tb.sv
